FILE: src/cbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counting Bloom filter store: shared definitions
// Field widths, request and status codes, and the control/status structs
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int unsigned IDX_W        = 10;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CTR_W        = 4;
  localparam int unsigned SUM_W        = CTR_W + 1;
  localparam int unsigned HASHES       = 4;
  localparam int unsigned HIDX_W       = $clog2(HASHES);
  localparam int unsigned COUNTERS_DEF = 1024;
  localparam int unsigned RECIP_W      = 20;

  localparam logic [CTR_W-1:0] CTR_MAX = CTR_W'((1 << CTR_W) - 1);

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic              load;
    logic              reduce;
    logic              rd;
    logic              wr;
    logic              clr;
    logic              finish;
    logic [HIDX_W-1:0] idx;
  } cbf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic wr_ok;
  } cbf_sts_t;

endpackage
`default_nettype wire

FILE: src/cbf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counting Bloom filter store: datapath
// Index reduction, single-port counter memory, new-value and status logic,
// and the result register.
// ----------------------------------------------------------------------------
module cbf_datapath #(
  parameter int unsigned COUNTERS = cbf_pkg::COUNTERS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cbf_pkg::cbf_cmd_t             cmd_i,
  input  wire logic [cbf_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [cbf_pkg::IDX_W-1:0]     idx_i [cbf_pkg::HASHES],
  output cbf_pkg::cbf_sts_t                  sts_o,
  output logic      [cbf_pkg::STATUS_W-1:0]  status_o
);
  import cbf_pkg::*;

  localparam int unsigned SLOT_W = $clog2(COUNTERS);
  localparam int unsigned CW     = $clog2(COUNTERS + 1);
  localparam int unsigned RW     = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned PROD_W = IDX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_W) / COUNTERS);
  localparam logic [IDX_W-1:0]   CMOD  = IDX_W'(COUNTERS % (1 << IDX_W));

  logic [IDX_W-1:0]    idx_q  [HASHES];
  logic [PROD_W-1:0]   prod_q [HASHES];
  logic [SLOT_W-1:0]   slot_q [HASHES];
  logic [CTR_W-1:0]    orig_q [HASHES];
  logic [CTR_W-1:0]    next_q [HASHES];
  logic [KIND_W-1:0]   kind_q;
  logic [STATUS_W-1:0] status_q;
  logic [SLOT_W-1:0]   clr_addr_q;

  logic [CTR_W-1:0]    mem_q [COUNTERS];

  logic [IDX_W-1:0]    qc_c   [HASHES];
  logic [IDX_W-1:0]    rem_c  [HASHES];
  logic [RW-1:0]       remw_c [HASHES];
  logic [SLOT_W-1:0]   slot_c [HASHES];
  logic [HIDX_W-1:0]   dup_c  [HASHES];
  logic [SUM_W-1:0]    sum_c  [HASHES];
  logic [CTR_W-1:0]    next_c [HASHES];
  logic                over_c;
  logic                present_c;
  logic [STATUS_W-1:0] res_c;

  logic [SLOT_W-1:0]   addr;
  logic [CTR_W-1:0]    wdata;
  logic                we;

  // remainder by the counter count: reciprocal estimate, one correction step
  always_comb begin
    for (int h = 0; h < HASHES; h++) begin
      qc_c[h]  = IDX_W'(prod_q[h][RECIP_W +: IDX_W] * CMOD);
      rem_c[h] = idx_q[h] - qc_c[h];
      remw_c[h] = RW'(rem_c[h]);
      if (remw_c[h] >= RW'(COUNTERS)) begin
        remw_c[h] = remw_c[h] - RW'(COUNTERS);
      end
      slot_c[h] = remw_c[h][SLOT_W-1:0];
    end
  end

  // earlier repeats of a slot shift the value seen by later hashes
  always_comb begin
    over_c    = 1'b0;
    present_c = 1'b1;
    for (int h = 0; h < HASHES; h++) begin
      dup_c[h] = '0;
      for (int j = 0; j < HASHES; j++) begin
        if (j < h && slot_q[j] == slot_q[h]) begin
          dup_c[h] = dup_c[h] + 1'b1;
        end
      end
      sum_c[h] = SUM_W'(orig_q[h]) + SUM_W'(dup_c[h]);
      if (sum_c[h] >= SUM_W'(CTR_MAX)) begin
        over_c = 1'b1;
      end
      if (orig_q[h] == '0) begin
        present_c = 1'b0;
      end
      if (kind_q == KIND_ADD) begin
        next_c[h] = CTR_W'(sum_c[h] + 1'b1);
      end else if (orig_q[h] > CTR_W'(dup_c[h])) begin
        next_c[h] = orig_q[h] - CTR_W'(dup_c[h]) - 1'b1;
      end else begin
        next_c[h] = '0;
      end
    end
    if (kind_q == KIND_ADD) begin
      res_c = over_c ? STATUS_OVERFLOW : STATUS_OK;
    end else begin
      res_c = present_c ? STATUS_OK : STATUS_ABSENT;
    end
  end

  assign sts_o.wr_ok    = (res_c == STATUS_OK) &&
                          (kind_q == KIND_ADD || kind_q == KIND_REMOVE);
  assign sts_o.clr_last = (clr_addr_q == SLOT_W'(COUNTERS - 1));

  assign addr  = cmd_i.clr ? clr_addr_q : slot_q[cmd_i.idx];
  assign wdata = cmd_i.clr ? '0 : next_q[cmd_i.idx];
  assign we    = cmd_i.clr || cmd_i.wr;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr] <= wdata;
    end
    if (cmd_i.rd) begin
      orig_q[cmd_i.idx] <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      for (int h = 0; h < HASHES; h++) begin
        idx_q[h]  <= idx_i[h];
        prod_q[h] <= PROD_W'(idx_i[h]) * PROD_W'(RECIP);
      end
    end
    if (cmd_i.reduce) begin
      for (int h = 0; h < HASHES; h++) begin
        slot_q[h] <= slot_c[h];
      end
    end
    if (cmd_i.finish) begin
      status_q <= res_c;
    end
    for (int h = 0; h < HASHES; h++) begin
      next_q[h] <= next_c[h];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_addr_q <= sts_o.clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  assign status_o = status_q;

endmodule
`default_nettype wire

FILE: src/cbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counting Bloom filter store: controller
// Sequences the clearing sweep, index reduction, counter reads and writes,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module cbf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire cbf_pkg::cbf_sts_t sts_i,
  output cbf_pkg::cbf_cmd_t      cmd_o
);
  import cbf_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_CALC,
    ST_WRITE
  } state_e;

  state_e            state_q, state_d;
  logic [HIDX_W-1:0] h_q, h_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              h_last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign h_last   = (h_q == HIDX_W'(HASHES - 1));

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    h_d     = h_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.reduce = 1'b1;
        h_d          = '0;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd  = 1'b1;
        cmd_o.idx = h_q;
        if (h_last) begin
          h_d     = '0;
          state_d = ST_CALC;
        end else begin
          h_d = h_q + 1'b1;
        end
      end
      ST_CALC: begin
        if (sts_i.wr_ok) begin
          state_d = ST_WRITE;
        end else if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_WRITE: begin
        cmd_o.idx = h_q;
        if (!h_last) begin
          cmd_o.wr = 1'b1;
          h_d      = h_q + 1'b1;
        end else if (out_free) begin
          cmd_o.wr     = 1'b1;
          cmd_o.finish = 1'b1;
          h_d          = '0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.finish || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: src/counting_bloom_filter_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counting Bloom filter store
// Counter store with 4-bit counters; add, remove and lookup by four
// precomputed hash indices, one status per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request that changes the store takes
// longer than a lookup, or an add or remove that is refused: the single
// port of the counter memory sets this, as each hash costs one read and,
// when the store changes, one write. In front, the load and reduce steps
// reduce the indices modulo COUNTERS. After reset the memory is swept to
// zero, one counter per cycle, and in_stall_o stays high until the sweep is
// done. A finished status sits in an output register, so the next request
// is taken while it waits.
module counting_bloom_filter_store #(
  parameter int unsigned COUNTERS = cbf_pkg::COUNTERS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [cbf_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [cbf_pkg::IDX_W-1:0]    index_a_i,
  input  wire logic [cbf_pkg::IDX_W-1:0]    index_b_i,
  input  wire logic [cbf_pkg::IDX_W-1:0]    index_c_i,
  input  wire logic [cbf_pkg::IDX_W-1:0]    index_d_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [cbf_pkg::STATUS_W-1:0] status_o
);
  import cbf_pkg::*;

  cbf_cmd_t         cmd;
  cbf_sts_t         sts;
  logic [IDX_W-1:0] idx [HASHES];

  assign idx[0] = index_a_i;
  assign idx[1] = index_b_i;
  assign idx[2] = index_c_i;
  assign idx[3] = index_d_i;

  cbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cbf_datapath #(
    .COUNTERS (COUNTERS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .kind_i   (kind_i),
    .idx_i    (idx),
    .sts_o    (sts),
    .status_o (status_o)
  );

  // single port: never a read together with a write
  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.rd && (cmd.wr || cmd.clr)))
    else $error("counter memory read and write in the same cycle");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || !out_stall_i))
    else $error("pending status overwritten");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.finish))
    else $error("status valid without a finished request");

endmodule
`default_nettype wire

FILE: tb/tb_counting_bloom_filter_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting Bloom filter store testbench
// Drives add, remove and lookup requests through the valid/stall input and
// checks each status against a 4-bit counter store model or a fixed status. A
// short directed table comes first, then random traffic aimed at a hot
// window of counters so that overflows and removals occur. Both sides idle
// at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_counting_bloom_filter_store;
  import cbf_pkg::*;

  localparam int unsigned N_CTR      = COUNTERS_DEF;
  localparam int unsigned N_RANDOM   = 650;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned DRAIN_CYC  = 40;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam bit TYPED = 1'b1;
  localparam bit MODEL = 1'b0;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] d;
  } idx_set_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    a;
    logic [IDX_W-1:0]    b;
    logic [IDX_W-1:0]    c;
    logic [IDX_W-1:0]    d;
    bit                  typed;
    logic [STATUS_W-1:0] status;
  } dir_row_t;

  localparam int unsigned N_DIR = 24;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{KIND_LOOKUP, 10'd0,    10'd0,    10'd0,    10'd0,    TYPED, STATUS_ABSENT},
    '{KIND_LOOKUP, 10'd1023, 10'd1023, 10'd1023, 10'd1023, TYPED, STATUS_ABSENT},
    '{KIND_REMOVE, 10'd0,    10'd1023, 10'd512,  10'd1,    TYPED, STATUS_ABSENT},
    '{KIND_UNUSED, 10'd0,    10'd0,    10'd0,    10'd0,    TYPED, STATUS_ABSENT},
    '{KIND_ADD,    10'd0,    10'd1023, 10'd341,  10'd682,  TYPED, STATUS_OK},
    '{KIND_LOOKUP, 10'd0,    10'd1023, 10'd341,  10'd682,  TYPED, STATUS_OK},
    '{KIND_UNUSED, 10'd682,  10'd341,  10'd1023, 10'd0,    TYPED, STATUS_OK},
    '{KIND_LOOKUP, 10'd0,    10'd1023, 10'd341,  10'd5,    TYPED, STATUS_ABSENT},
    '{KIND_ADD,    10'd5,    10'd5,    10'd5,    10'd5,    TYPED, STATUS_OK},
    '{KIND_ADD,    10'd5,    10'd5,    10'd5,    10'd5,    TYPED, STATUS_OK},
    '{KIND_ADD,    10'd5,    10'd5,    10'd5,    10'd5,    TYPED, STATUS_OK},
    '{KIND_ADD,    10'd5,    10'd5,    10'd5,    10'd5,    TYPED, STATUS_OVERFLOW},
    '{KIND_LOOKUP, 10'd5,    10'd5,    10'd5,    10'd5,    MODEL, STATUS_OK},
    '{KIND_ADD,    10'd1023, 10'd1023, 10'd1023, 10'd1023, MODEL, STATUS_OK},
    '{KIND_ADD,    10'd7,    10'd8,    10'd9,    10'd10,   MODEL, STATUS_OK},
    '{KIND_REMOVE, 10'd7,    10'd7,    10'd8,    10'd9,    MODEL, STATUS_OK},
    '{KIND_LOOKUP, 10'd7,    10'd8,    10'd9,    10'd10,   MODEL, STATUS_OK},
    '{KIND_REMOVE, 10'd0,    10'd1023, 10'd341,  10'd682,  MODEL, STATUS_OK},
    '{KIND_REMOVE, 10'd5,    10'd5,    10'd5,    10'd5,    MODEL, STATUS_OK},
    '{KIND_ADD,    10'd1023, 10'd1023, 10'd0,    10'd0,    MODEL, STATUS_OK},
    '{KIND_REMOVE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, MODEL, STATUS_OK},
    '{KIND_LOOKUP, 10'd1023, 10'd0,    10'd682,  10'd341,  MODEL, STATUS_OK},
    '{KIND_ADD,    10'd682,  10'd682,  10'd682,  10'd682,  MODEL, STATUS_OK},
    '{KIND_REMOVE, 10'd1023, 10'd0,    10'd1,    10'd2,    MODEL, STATUS_OK}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [KIND_W-1:0]   kind_i;
  logic [IDX_W-1:0]    index_a_i;
  logic [IDX_W-1:0]    index_b_i;
  logic [IDX_W-1:0]    index_c_i;
  logic [IDX_W-1:0]    index_d_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;

  logic [CTR_W-1:0]    ctr_q [N_CTR];
  logic [STATUS_W-1:0] status_q [$];
  idx_set_t            added_q [$];
  int unsigned         n_errors;
  int unsigned         n_results;
  int unsigned         idle_cycles;
  int unsigned         burst_left;

  counting_bloom_filter_store i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .index_a_i  (index_a_i),
    .index_b_i  (index_b_i),
    .index_c_i  (index_c_i),
    .index_d_i  (index_d_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Applies one request to the local counter store and returns its status.
  function automatic logic [STATUS_W-1:0] update_counters(logic [KIND_W-1:0] kind,
                                                          idx_set_t s);
    logic [IDX_W-1:0] slot [HASHES];
    logic [SUM_W:0]   v;
    logic [SUM_W:0]   nxt [HASHES];
    bit               over;
    bit               present;
    slot[0] = IDX_W'(s.a % N_CTR);
    slot[1] = IDX_W'(s.b % N_CTR);
    slot[2] = IDX_W'(s.c % N_CTR);
    slot[3] = IDX_W'(s.d % N_CTR);
    present = 1'b1;
    for (int i = 0; i < HASHES; i++) begin
      if (ctr_q[slot[i]] == '0) present = 1'b0;
    end
    if (kind == KIND_ADD) begin
      over = 1'b0;
      for (int i = 0; i < HASHES; i++) begin
        v = (SUM_W+1)'(ctr_q[slot[i]]);
        for (int j = 0; j < i; j++) begin
          if (slot[j] == slot[i]) v = v + 1'b1;
        end
        if (v >= (SUM_W+1)'(CTR_MAX)) over = 1'b1;
        nxt[i] = v + 1'b1;
      end
      if (over) return STATUS_OVERFLOW;
      // later repeats carry the higher value, so writing in order is right
      for (int i = 0; i < HASHES; i++) ctr_q[slot[i]] = nxt[i][CTR_W-1:0];
      return STATUS_OK;
    end else if (kind == KIND_REMOVE) begin
      if (!present) return STATUS_ABSENT;
      for (int i = 0; i < HASHES; i++) begin
        if (ctr_q[slot[i]] != '0) ctr_q[slot[i]] = ctr_q[slot[i]] - 1'b1;
      end
      return STATUS_OK;
    end
    return present ? STATUS_OK : STATUS_ABSENT;
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input idx_set_t s,
                              input bit typed, input logic [STATUS_W-1:0] typed_status);
    logic [STATUS_W-1:0] exp_status;
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    index_a_i  <= s.a;
    index_b_i  <= s.b;
    index_c_i  <= s.c;
    index_d_i  <= s.d;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    exp_status = update_counters(kind, s);
    if (typed) exp_status = typed_status;
    status_q.push_back(exp_status);
    if (kind == KIND_ADD && exp_status == STATUS_OK) begin
      added_q.push_back(s);
      if (added_q.size() > 32) void'(added_q.pop_front());
    end
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  // Random request: mostly a hot window of counters, sometimes a repeat of
  // an earlier add, sometimes fully random.
  task automatic random_request(input logic [IDX_W-1:0] hot_base);
    logic [KIND_W-1:0] kind;
    idx_set_t          s;
    int unsigned       pick;
    int unsigned       src;
    pick = $urandom_range(0, 99);
    if (pick < 40)      kind = KIND_ADD;
    else if (pick < 70) kind = KIND_REMOVE;
    else if (pick < 95) kind = KIND_LOOKUP;
    else                kind = KIND_UNUSED;
    src = $urandom_range(0, 9);
    if (kind != KIND_ADD && added_q.size() != 0 && src < 5) begin
      s = added_q[$urandom_range(0, added_q.size() - 1)];
    end else if (src < 8) begin
      s.a = hot_base + IDX_W'($urandom_range(0, 7));
      s.b = hot_base + IDX_W'($urandom_range(0, 7));
      s.c = hot_base + IDX_W'($urandom_range(0, 7));
      s.d = hot_base + IDX_W'($urandom_range(0, 7));
    end else begin
      s.a = IDX_W'($urandom);
      s.b = IDX_W'($urandom);
      s.c = IDX_W'($urandom);
      s.d = IDX_W'($urandom);
    end
    send_request(kind, s, MODEL, STATUS_OK);
  endtask

  initial begin
    logic [IDX_W-1:0] hot_base;
    idx_set_t         s;
    for (int i = 0; i < N_CTR; i++) ctr_q[i] = '0;
    n_errors   = 0;
    burst_left = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    kind_i     <= KIND_ADD;
    index_a_i  <= '0;
    index_b_i  <= '0;
    index_c_i  <= '0;
    index_d_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < N_DIR; r++) begin
      s = '{DIR_TAB[r].a, DIR_TAB[r].b, DIR_TAB[r].c, DIR_TAB[r].d};
      send_request(DIR_TAB[r].kind, s, DIR_TAB[r].typed, DIR_TAB[r].status);
    end
    hot_base = IDX_W'($urandom);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 149) hot_base = IDX_W'($urandom);
      random_request(hot_base);
    end
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb_counting_bloom_filter_store OK");
    end else begin
      $display("tb_counting_bloom_filter_store NOT OK");
    end
    $finish;
  end

  // Receiver stall pattern, with one long hold-off once results are flowing.
  initial begin
    int unsigned hold_cnt;
    int unsigned seg_left;
    int unsigned seg_mode;
    bit          hold_done;
    hold_cnt  = 0;
    seg_left  = 0;
    seg_mode  = 0;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && n_results >= 40) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_LEN;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        case (seg_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          2: out_stall_i <= (seg_left % 5 < 2);
          default: out_stall_i <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  initial n_results = 0;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results <= n_results + 1;
      if (status_q.size() == 0) begin
        $display("%0t: unexpected status transfer: expected none, actual %0d",
                 $time, status_o);
        n_errors++;
      end else if (status_o !== status_q[0]) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, status_q[0], status_o);
        n_errors++;
        void'(status_q.pop_front());
      end else begin
        void'(status_q.pop_front());
      end
    end
  end

  initial idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("tb_counting_bloom_filter_store NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
